// ===== hw/rtl/hcl_pkg.sv =====
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared types and constants of the hit cluster labeler: slot count, field
// widths, the hit word, the control word sent to the slot cells and the word
// carried by the oldest-slot chain.
// ----------------------------------------------------------------------------
`default_nettype none

package hcl_pkg;

  // Number of cluster slots (one cell each)
  localparam int NUM_CLUSTERS = 16;
  localparam int IDX_W        = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  // Counter that can hold NUM_CLUSTERS itself
  localparam int CNT_W        = $clog2(NUM_CLUSTERS + 1);

  localparam int COORD_W      = 10;
  localparam int TIME_W       = 48;
  localparam int WIN_W        = 32;
  localparam int LABEL_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_WINDOW    = 2'd0,
    REG_SPATIAL_MARGIN = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_DECIDE
  } state_e;

  // One hit
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  t;
  } hit_t;

  // Running oldest-slot word handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] t;
    logic [IDX_W-1:0]  idx;
  } min_t;

  // Update command broadcast to all cells
  typedef struct packed {
    logic               commit;
    logic               evict;
    logic               clear;
    logic [LABEL_W-1:0] new_label;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hit_cluster_labeler_unit.sv =====
// When a slot takes the hit, the result word is loaded from ST_DECIDE into the
// output register once that register is free. Eviction waits until the
// oldest-slot chain has settled after the last slot update. A new hit is
// accepted only in ST_IDLE, after the previous one has been committed;
// evictions and output stalls delay that commit.
// Reset (async, active low) empties all slots, label counter to NUM_CLUSTERS.
// ----------------------------------------------------------------------------
// hit_cluster_labeler_unit
// Top level: a row of slot cells, first-taker select, eviction via the
// oldest-slot chain, label counter, config registers and the output register.
// Reset also sets time_window 75 and spatial_margin 1.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_cluster_labeler_unit import hcl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // hit input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_W-1:0]    hit_x_i,
  input  logic [COORD_W-1:0]    hit_y_i,
  input  logic [TIME_W-1:0]     hit_time_i,
  input  logic                  last_in_batch_i,
  // label output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LABEL_W-1:0]    label_o,
  output logic                  evicted_o
);

  state_e               state_q, state_d;
  logic [WIN_W-1:0]     win_q;
  logic [COORD_W-1:0]   margin_q;
  logic [LABEL_W-1:0]   next_label_q, next_label_d;
  logic [CNT_W-1:0]     settle_q, settle_d;
  hit_t                 hit_in, hit_q;
  logic                 last_q;
  logic                 out_valid_q, out_valid_d;
  logic [LABEL_W-1:0]   out_label_q, out_label_d;
  logic                 out_evict_q, out_evict_d;

  logic                 in_acc;
  logic                 commit;
  cell_ctrl_t           ctrl;
  logic [NUM_CLUSTERS-1:0] take, first_oh, evict_oh, sel;
  logic [LABEL_W-1:0]   cell_label [NUM_CLUSTERS];
  min_t                 chain [NUM_CLUSTERS+1];
  logic                 any_take, can_write, ready_go;
  logic [LABEL_W-1:0]   sel_label;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign hit_in.x = hit_x_i;
  assign hit_in.y = hit_y_i;
  assign hit_in.t = hit_time_i;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WIN_W'(75);
      margin_q <= COORD_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TIME_WINDOW:    win_q    <= cfg_data_i[WIN_W-1:0];
        REG_SPATIAL_MARGIN: margin_q <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the hit for the update cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hit_q  <= hit_in;
      last_q <= last_in_batch_i;
    end
  end

  // Slot row
  assign chain[0] = '0;
  for (genvar i = 0; i < NUM_CLUSTERS; i++) begin : g_cell
    hcl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .win_i      (win_q),
      .margin_i   (margin_q),
      .eval_i     (in_acc),
      .hit_in_i   (hit_in),
      .hit_q_i    (hit_q),
      .ctrl_i     (ctrl),
      .sel_i      (sel[i]),
      .min_i      (chain[i]),
      .take_o     (take[i]),
      .label_o    (cell_label[i]),
      .min_o      (chain[i+1])
    );
  end

  // First taker, or the oldest slot when none takes the hit
  always_comb begin
    any_take = |take;
    first_oh = take & (~take + NUM_CLUSTERS'(1));
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      evict_oh[i] = (chain[NUM_CLUSTERS].idx == IDX_W'(i));
    end
    sel       = any_take ? first_oh : evict_oh;
    sel_label = '0;
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      sel_label = sel_label | (sel[i] ? cell_label[i] : '0);
    end
  end

  // Sequencer: next state, commit and output register load
  always_comb begin
    state_d      = state_q;
    can_write    = !out_valid_q || !out_stall_i;
    ready_go     = any_take || (settle_q == CNT_W'(NUM_CLUSTERS));
    commit       = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_label_d  = out_label_q;
    out_evict_d  = out_evict_q;
    next_label_d = next_label_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (can_write && ready_go) begin
          commit      = 1'b1;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_evict_d = !any_take;
          out_label_d = any_take ? sel_label : next_label_q;
          if (!any_take) next_label_d = next_label_q + LABEL_W'(1);
          if (last_q) next_label_d = LABEL_W'(NUM_CLUSTERS);
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ctrl.commit    = commit;
    ctrl.evict     = !any_take;
    ctrl.clear     = commit && last_q;
    ctrl.new_label = next_label_q;
    // cycles since the slot row last changed
    if (commit) settle_d = '0;
    else if (settle_q != CNT_W'(NUM_CLUSTERS)) settle_d = settle_q + CNT_W'(1);
    else settle_d = settle_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      next_label_q <= LABEL_W'(NUM_CLUSTERS);
      settle_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_label_q <= next_label_d;
      settle_q     <= settle_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    out_label_q <= out_label_d;
    out_evict_q <= out_evict_d;
  end

  assign out_valid_o = out_valid_q;
  assign label_o     = out_label_q;
  assign evicted_o   = out_evict_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hcl_cell.sv =====
// ----------------------------------------------------------------------------
// hcl_cell
// One cluster slot: holds occupancy, bounding box, first-hit time and label.
// Registers whether it would take an incoming hit, applies start/grow/clear
// updates, and forwards the oldest (time, index) seen so far to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module hcl_cell import hcl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    cell_idx_i,
  input  logic [WIN_W-1:0]    win_i,
  input  logic [COORD_W-1:0]  margin_i,
  input  logic                eval_i,
  input  hit_t                hit_in_i,
  input  hit_t                hit_q_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic                sel_i,
  input  min_t                min_i,
  output logic                take_o,
  output logic [LABEL_W-1:0]  label_o,
  output min_t                min_o
);

  logic               occ_q, occ_d;
  logic               lbl_set_q, lbl_set_d;
  logic               take_q, take_d;
  logic [COORD_W-1:0] xmin_q, xmin_d, xmax_q, xmax_d;
  logic [COORD_W-1:0] ymin_q, ymin_d, ymax_q, ymax_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic [LABEL_W-1:0] label_q, label_d;
  min_t               min_q, min_d;

  logic [TIME_W-1:0]  t_dist;
  logic               t_ok, box_ok;
  logic [COORD_W:0]   x_lo, x_hi, y_lo, y_hi;

  // Accept test against the live hit
  always_comb begin
    t_dist = (hit_in_i.t >= time_q) ? (hit_in_i.t - time_q) : (time_q - hit_in_i.t);
    t_ok   = (t_dist <= {{(TIME_W-WIN_W){1'b0}}, win_i});
    x_lo   = {1'b0, hit_in_i.x} + {1'b0, margin_i};
    x_hi   = {1'b0, xmax_q} + {1'b0, margin_i};
    y_lo   = {1'b0, hit_in_i.y} + {1'b0, margin_i};
    y_hi   = {1'b0, ymax_q} + {1'b0, margin_i};
    box_ok = (x_lo >= {1'b0, xmin_q}) && ({1'b0, hit_in_i.x} <= x_hi) &&
             (y_lo >= {1'b0, ymin_q}) && ({1'b0, hit_in_i.y} <= y_hi);
    take_d = eval_i ? (!occ_q || (t_ok && box_ok)) : take_q;
  end

  // Slot update: clear wins, then start (empty or evicted) or grow
  always_comb begin
    occ_d     = occ_q;
    lbl_set_d = lbl_set_q;
    xmin_d    = xmin_q;
    xmax_d    = xmax_q;
    ymin_d    = ymin_q;
    ymax_d    = ymax_q;
    time_d    = time_q;
    label_d   = label_q;
    if (ctrl_i.clear) begin
      occ_d     = 1'b0;
      lbl_set_d = 1'b0;
    end else if (ctrl_i.commit && sel_i) begin
      if (ctrl_i.evict || !occ_q) begin
        occ_d  = 1'b1;
        xmin_d = hit_q_i.x;
        xmax_d = hit_q_i.x;
        ymin_d = hit_q_i.y;
        ymax_d = hit_q_i.y;
        time_d = hit_q_i.t;
        if (ctrl_i.evict) begin
          lbl_set_d = 1'b1;
          label_d   = ctrl_i.new_label;
        end
      end else begin
        if (hit_q_i.x < xmin_q) xmin_d = hit_q_i.x;
        if (hit_q_i.x > xmax_q) xmax_d = hit_q_i.x;
        if (hit_q_i.y < ymin_q) ymin_d = hit_q_i.y;
        if (hit_q_i.y > ymax_q) ymax_d = hit_q_i.y;
      end
    end
  end

  // Oldest chain: replace only on strictly older, so lower index wins ties
  always_comb begin
    if (!min_i.vld || (time_q < min_i.t)) begin
      min_d.vld = 1'b1;
      min_d.t   = time_q;
      min_d.idx = cell_idx_i;
    end else begin
      min_d = min_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= 1'b0;
      lbl_set_q <= 1'b0;
      take_q    <= 1'b0;
      min_q     <= '0;
    end else begin
      occ_q     <= occ_d;
      lbl_set_q <= lbl_set_d;
      take_q    <= take_d;
      min_q     <= min_d;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    xmin_q  <= xmin_d;
    xmax_q  <= xmax_d;
    ymin_q  <= ymin_d;
    ymax_q  <= ymax_d;
    time_q  <= time_d;
    label_q <= label_d;
  end

  assign take_o  = take_q;
  assign label_o = lbl_set_q ? label_q : LABEL_W'(cell_idx_i);
  assign min_o   = min_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hcl_checker.sv =====
// ----------------------------------------------------------------------------
// hcl_checker
// Port-level checks of the hit cluster labeler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcl_checker import hcl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [LABEL_W-1:0]    label_o,
  input  logic                  evicted_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(label_o) && $stable(evicted_o))
    else $error("stalled output word changed");

  // one hit in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second hit accepted while one is in work");

  // a new result only appears while a hit is in work
  a_rise_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no hit in work");

  // a word presented with no stall while no hit is in work is gone the next cycle
  a_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_stall_o |=> !out_valid_o)
    else $error("output word repeated");

endmodule

bind hit_cluster_labeler_unit hcl_checker u_hcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .label_o     (label_o),
  .evicted_o   (evicted_o)
);

`default_nettype wire
